[hdl/fpmdu_pkg.sv]
// fpmdu_pkg: types and constants for the fixed-point multiply / divide unit
// used by fpmdu_core and fixed_point_mul_div_unit, no dependencies
package fpmdu_pkg;

  typedef enum logic [3:0] {
    CMD_MUL16      = 4'd0,
    CMD_MUL16SHIFT = 4'd1,
    CMD_MUL32      = 4'd2,
    CMD_DIV16      = 4'd3,
    CMD_DIV16SHIFT = 4'd4,
    CMD_DIV32      = 4'd5,
    CMD_INV16      = 4'd6,
    CMD_INV16SHIFT = 4'd7,
    CMD_INV32      = 4'd8
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_MUL  = 2'd1,
    KIND_DIV  = 2'd2
  } kind_e;

  localparam int unsigned QW       = 40;
  localparam int unsigned STEPS    = 4;
  localparam int unsigned NSTAGE   = QW / STEPS;
  localparam logic [3:0]  Q8_SHIFT = 4'd8;
  localparam logic [QW-1:0] Q16_ONE = QW'(32'h0001_0000);
  localparam logic [QW-1:0] Q8_ONE  = QW'(32'h0000_0100);

  typedef struct packed {
    logic [3:0]         cmd;
    logic [3:0]         shift_amount;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;
  } in_t;

  typedef struct packed {
    logic signed [31:0] result;
    logic               divide_by_zero;
  } out_t;

  typedef struct packed {
    kind_e              kind;
    logic               wide16;
    logic               neg;
    logic               dz;
    logic [3:0]         sh;
    logic signed [31:0] ma;
    logic signed [31:0] mb;
    logic signed [63:0] prod;
    logic [31:0]        rem;
    logic [QW-1:0]      num;
    logic [31:0]        den;
  } stage_t;

endpackage

[hdl/fpmdu_core.sv]
// fpmdu_core: decode, 32x32 multiply with rounding shift and a 40-bit
// restoring divider, one pipeline stage per four quotient bits; uses fpmdu_pkg
module fpmdu_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               vld_i,
  input  fpmdu_pkg::in_t     op_i,
  output logic               vld_o,
  output fpmdu_pkg::out_t    res_o
);
  import fpmdu_pkg::*;

  stage_t             dec_d;
  stage_t             pipe_q [NSTAGE+1];
  stage_t             pipe_d [NSTAGE+1];
  logic [NSTAGE:0]    vld_q;
  out_t               res_d, res_q;
  logic               vld_out_q;

  logic signed [31:0] a16, b16;
  logic [31:0]        amag;
  logic               sa, sb;

  always_comb begin
    a16 = 32'(signed'(op_i.operand_a[15:0]));
    b16 = 32'(signed'(op_i.operand_b[15:0]));
    dec_d = '0;
    dec_d.kind = KIND_NONE;
    case (op_i.cmd)
      CMD_MUL16, CMD_MUL16SHIFT, CMD_DIV16, CMD_DIV16SHIFT, CMD_INV16, CMD_INV16SHIFT: begin
        dec_d.wide16 = 1'b1;
      end
      default: begin
        dec_d.wide16 = 1'b0;
      end
    endcase
    dec_d.ma = dec_d.wide16 ? a16 : op_i.operand_a;
    dec_d.mb = dec_d.wide16 ? b16 : op_i.operand_b;
    sa = dec_d.ma[31];
    sb = dec_d.mb[31];
    amag = sa ? 32'(-dec_d.ma) : 32'(dec_d.ma);
    dec_d.den = sb ? 32'(-dec_d.mb) : 32'(dec_d.mb);
    dec_d.dz = (dec_d.mb == '0);
    dec_d.sh = (op_i.cmd == CMD_MUL16SHIFT) ? op_i.shift_amount : Q8_SHIFT;
    dec_d.neg = sa ^ sb;
    case (op_i.cmd)
      CMD_MUL16, CMD_MUL16SHIFT, CMD_MUL32: begin
        dec_d.kind = KIND_MUL;
        dec_d.dz = 1'b0;
      end
      CMD_DIV16, CMD_DIV32: begin
        dec_d.kind = KIND_DIV;
        dec_d.num = {8'd0, amag} << 8;
      end
      CMD_DIV16SHIFT: begin
        dec_d.kind = KIND_DIV;
        dec_d.num = {8'd0, amag} << op_i.shift_amount;
      end
      CMD_INV16, CMD_INV32: begin
        dec_d.kind = KIND_DIV;
        dec_d.num = Q16_ONE;
        dec_d.neg = sb;
      end
      CMD_INV16SHIFT: begin
        dec_d.kind = KIND_DIV;
        dec_d.num = Q8_ONE << op_i.shift_amount;
        dec_d.neg = sb;
      end
      default: begin
        dec_d.kind = KIND_NONE;
        dec_d.dz = 1'b0;
      end
    endcase
  end

  logic [32:0]   t;
  logic [15:0]   bias;

  always_comb begin
    pipe_d[0] = dec_d;
    t = '0;
    bias = '0;
    for (int i = 1; i <= NSTAGE; i++) begin
      pipe_d[i] = pipe_q[i-1];
      if (i == 1) begin
        pipe_d[i].prod = 64'(pipe_q[i-1].ma) * 64'(pipe_q[i-1].mb);
      end
      if (i == 2) begin
        bias = pipe_q[i-1].prod[63] ? ((16'd1 << pipe_q[i-1].sh) - 16'd1) : 16'd0;
        pipe_d[i].prod = (pipe_q[i-1].prod + 64'(bias)) >>> pipe_q[i-1].sh;
      end
      for (int j = 0; j < STEPS; j++) begin
        t = {pipe_d[i].rem, pipe_d[i].num[QW-1]};
        pipe_d[i].num = {pipe_d[i].num[QW-2:0], 1'b0};
        if (t >= {1'b0, pipe_d[i].den}) begin
          t = t - {1'b0, pipe_d[i].den};
          pipe_d[i].num[0] = 1'b1;
        end
        pipe_d[i].rem = t[31:0];
      end
    end
  end

  logic [31:0] v;

  always_comb begin
    v = '0;
    case (pipe_q[NSTAGE].kind)
      KIND_MUL: v = pipe_q[NSTAGE].prod[31:0];
      KIND_DIV: begin
        v = pipe_q[NSTAGE].neg ? 32'(-pipe_q[NSTAGE].num[31:0]) : pipe_q[NSTAGE].num[31:0];
      end
      default:  v = '0;
    endcase
    if (pipe_q[NSTAGE].dz) begin
      v = '0;
    end
    if (pipe_q[NSTAGE].wide16) begin
      v = {{16{v[15]}}, v[15:0]};
    end
    res_d.result = v;
    res_d.divide_by_zero = pipe_q[NSTAGE].dz;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      vld_out_q <= 1'b0;
    end else begin
      vld_q <= {vld_q[NSTAGE-1:0], vld_i};
      vld_out_q <= vld_q[NSTAGE];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i <= NSTAGE; i++) begin
      pipe_q[i] <= pipe_d[i];
    end
    res_q <= res_d;
  end

  assign vld_o = vld_out_q;
  assign res_o = res_q;

endmodule

[hdl/fixed_point_mul_div_unit.sv]
// fixed_point_mul_div_unit: top level of the signed q8 multiply / divide unit
// depends on fpmdu_pkg and fpmdu_core
//
// One word may be started in every cycle; busy is never raised and the
// receiver cannot stall, so results must be taken when they appear. Each
// result appears on res_o with valid_o high for one cycle, after passing through
// one decode stage, ten divider stages that retire four quotient bits each (the
// multiply and its rounding shift ride along in the first two), and the output
// register.
module fixed_point_mul_div_unit (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  fpmdu_pkg::in_t   op_i,
  output logic             valid_o,
  output fpmdu_pkg::out_t  res_o
);
  import fpmdu_pkg::*;

  logic accept;

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  fpmdu_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (accept),
    .op_i   (op_i),
    .vld_o  (valid_o),
    .res_o  (res_o)
  );

endmodule

[bench/tb_fixed_point_mul_div_unit.sv]
// tb_fixed_point_mul_div_unit: self-checking bench for the signed q8 multiply / divide unit
// drives words through start/busy, predicts each result and checks it from a scoreboard
// depends on fpmdu_pkg and fixed_point_mul_div_unit
`timescale 1ns / 1ps

module tb_fixed_point_mul_div_unit;
  import fpmdu_pkg::*;

  localparam int LATENCY  = 12;
  localparam int WATCHDOG = 5000;

  class fpmdu_scoreboard;
    out_t pending[$];
    int   mismatches;
    int   checked;

    function automatic longint sext16(logic [31:0] v);
      return longint'($signed(v[15:0]));
    endfunction

    function automatic logic [31:0] wrap16(longint v);
      logic [15:0] lo;
      lo = v[15:0];
      return {{16{lo[15]}}, lo};
    endfunction

    function automatic out_t compute(in_t w);
      out_t   r;
      longint a32, b32, a16, b16, scale;
      a32 = longint'(w.operand_a);
      b32 = longint'(w.operand_b);
      a16 = sext16(w.operand_a);
      b16 = sext16(w.operand_b);
      scale = longint'(1) << w.shift_amount;
      r = '0;
      case (w.cmd)
        CMD_MUL16:      r.result = wrap16((a16 * b16) / 256);
        CMD_MUL16SHIFT: r.result = wrap16((a16 * b16) / scale);
        CMD_MUL32:      r.result = 32'((a32 * b32) / 256);
        CMD_DIV16: begin
          if (b16 == 0) r.divide_by_zero = 1'b1;
          else r.result = wrap16((a16 * 256) / b16);
        end
        CMD_DIV16SHIFT: begin
          if (b16 == 0) r.divide_by_zero = 1'b1;
          else r.result = wrap16((a16 * scale) / b16);
        end
        CMD_DIV32: begin
          if (b32 == 0) r.divide_by_zero = 1'b1;
          else r.result = 32'((a32 * 256) / b32);
        end
        CMD_INV16: begin
          if (b16 == 0) r.divide_by_zero = 1'b1;
          else r.result = wrap16(longint'(65536) / b16);
        end
        CMD_INV16SHIFT: begin
          if (b16 == 0) r.divide_by_zero = 1'b1;
          else r.result = wrap16((256 * scale) / b16);
        end
        CMD_INV32: begin
          if (b32 == 0) r.divide_by_zero = 1'b1;
          else r.result = 32'(longint'(65536) / b32);
        end
        default: r = '0;
      endcase
      return r;
    endfunction

    function void note_word(in_t w);
      pending.push_back(compute(w));
    endfunction

    function void check_result(out_t got);
      out_t want;
      checked++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
        return;
      end
      want = pending.pop_front();
      if (got.result !== want.result || got.divide_by_zero !== want.divide_by_zero) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected result %h dz %b, got result %h dz %b",
                   want.result, want.divide_by_zero, got.result, got.divide_by_zero);
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_t  op_i = '0;
  logic valid_o;
  out_t res_o;

  fpmdu_scoreboard board = new();
  int idle_cycles;
  int words_sent;

  always #1 clk_i = ~clk_i;

  fixed_point_mul_div_unit i_dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .op_i(op_i), .valid_o(valid_o), .res_o(res_o)
  );

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) board.note_word(op_i);
      if (valid_o) board.check_result(res_o);
      if ((start && !busy) || valid_o) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  always @(posedge clk_i) begin
    if (idle_cycles >= WATCHDOG) begin
      $display("watchdog expired");
      $display("Regression FAIL");
      $finish;
    end
  end

  // hold one word until accepted; start stays high for back-to-back words
  task automatic send_word(in_t w, bit last_in_burst);
    op_i  <= w;
    start <= 1'b1;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    words_sent++;
    if (last_in_burst) start <= 1'b0;
  endtask

  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'(int'($urandom_range(0, 4)) - 2);
      3: return {{16{1'b0}}, 16'($urandom)};
      4: return {16'($urandom), 16'h0000};
      5: return 32'($signed(16'($urandom)));
      default: return $urandom;
    endcase
  endfunction

  function automatic in_t random_word();
    in_t w;
    w.cmd = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(9, 15))
                                          : 4'($urandom_range(0, 8));
    w.shift_amount = 4'($urandom);
    w.operand_a = pick_operand();
    w.operand_b = pick_operand();
    return w;
  endfunction

  task automatic drain();
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  in_t directed[$];
  in_t w;
  int  burst;

  initial begin
    idle_cycles = 0;
    words_sent = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int c = 0; c <= 8; c++) begin
      w.cmd = 4'(c); w.shift_amount = 4'(c == 4 ? 0 : 15);
      w.operand_a = 32'h8000_0000; w.operand_b = 32'hffff_ffff;
      directed.push_back(w);
      w.operand_a = 32'h7fff_7fff; w.operand_b = 32'h0001_0000;
      directed.push_back(w);
    end
    w.cmd = CMD_MUL32; w.operand_a = 32'h7fff_ffff; w.operand_b = 32'h7fff_ffff;
    directed.push_back(w);
    w.cmd = CMD_DIV32; w.operand_a = 32'hffff_ff00; w.operand_b = 32'd3;
    directed.push_back(w);
    w.cmd = CMD_INV32; w.operand_b = 32'd0;
    directed.push_back(w);
    w.cmd = 4'd15; w.operand_a = 32'hffff_ffff; w.operand_b = 32'hffff_ffff;
    directed.push_back(w);
    foreach (directed[i]) send_word(directed[i], i == directed.size() - 1);

    drain();

    while (words_sent < 1850) begin
      burst = ($urandom_range(0, 3) == 0) ? 200 : $urandom_range(1, 12);
      if (burst > 1850 - words_sent) burst = 1850 - words_sent;
      for (int i = 0; i < burst; i++) send_word(random_word(), i == burst - 1);
      if (words_sent > 900 && words_sent < 960) drain();
      else repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 15)) @(posedge clk_i);
    end

    drain();
    $display("sent %0d words over all nine commands and unused codes, checked %0d results",
             words_sent, board.checked);
    if (board.mismatches == 0 && board.pending.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches, %0d results missing", board.mismatches,
               board.pending.size());
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
